FILE: hdl/rsp_pkg.sv
// rsp_pkg: shared constants, word types and gf(256) helpers for the
// reed-solomon parity encoder; no dependencies
package rsp_pkg;

  localparam int MAX_PARITY = 30;
  localparam int CNT_W = $clog2(MAX_PARITY + 1);
  localparam int PADDR_W = 3;

  localparam logic [CNT_W-1:0] RESET_PARITY = CNT_W'(10);
  localparam logic [7:0] FIELD_REDUCE = 8'h1d;
  localparam logic [7:0] GF_ONE = 8'h01;

  // register index decoded from paddr[2]
  localparam logic REG_PARITY_COUNT = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       last_parity;
  } out_word_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic clear;   // zero generator and remainder
    logic build;   // one generator rebuild step
    logic encode;  // one data byte enters the lfsr
    logic load;    // capture remainder into output chain
    logic drain;   // shift output chain by one byte
  } cell_cmd_t;

  // multiply by x modulo the field polynomial
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_REDUCE : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = gf_xtime(x);
    end
    gf_mul = acc;
  endfunction

endpackage

FILE: hdl/rsp_cell.sv
// rsp_cell: one lfsr stage holding a remainder byte, a generator
// coefficient and one byte of the parity output chain; uses rsp_pkg
module rsp_cell import rsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  logic [7:0] fb,
  input  logic [7:0] root,
  input  logic [7:0] g_left,
  input  logic [7:0] r_right,
  input  logic [7:0] par_right,
  output logic [7:0] g,
  output logic [7:0] r,
  output logic [7:0] par
);

  logic [7:0] mul_a;
  logic [7:0] mul_b;
  logic [7:0] prod;
  logic [7:0] r_next;

  // one multiplier, shared between rebuild and encode
  assign mul_a  = cmd.build ? g_left : g;
  assign mul_b  = cmd.build ? root : fb;
  assign prod   = gf_mul(mul_a, mul_b);
  assign r_next = r_right ^ prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      g <= 8'h00;
      r <= 8'h00;
    end else if (cmd.clear) begin
      g <= 8'h00;
      r <= 8'h00;
    end else if (cmd.build) begin
      g <= g ^ prod;
    end else if (cmd.encode) begin
      r <= cmd.load ? 8'h00 : r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      par <= r_next;
    end else if (cmd.drain) begin
      par <= par_right;
    end
  end

endmodule

FILE: hdl/rsp_cfg.sv
// rsp_cfg: apb register for the parity count and the generator rebuild
// sequencer; uses rsp_pkg
module rsp_cfg import rsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               clear,
  output logic               build,
  output logic [7:0]         root,
  output logic [CNT_W-1:0]   n_active
);

  logic             wr_en;
  logic [CNT_W-1:0] wr_count;
  logic [CNT_W-1:0] step_cnt;
  logic             busy;

  assign wr_en = psel & penable & pwrite & (paddr[2] == REG_PARITY_COUNT);

  always_comb begin
    priority if (pwdata[CNT_W-1:0] == '0) begin
      wr_count = CNT_W'(1);
    end else if (pwdata[CNT_W-1:0] > CNT_W'(MAX_PARITY)) begin
      wr_count = CNT_W'(MAX_PARITY);
    end else begin
      wr_count = pwdata[CNT_W-1:0];
    end
  end

  assign clear = wr_en;
  assign build = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_active <= RESET_PARITY;
      step_cnt <= RESET_PARITY;
      root     <= GF_ONE;
      busy     <= 1'b1;
    end else if (wr_en) begin
      n_active <= wr_count;
      step_cnt <= wr_count;
      root     <= GF_ONE;
      busy     <= 1'b1;
    end else if (busy) begin
      step_cnt <= step_cnt - CNT_W'(1);
      root     <= gf_xtime(root);
      busy     <= (step_cnt != CNT_W'(1));
    end
  end

  always_comb begin
    if (paddr[2] == REG_PARITY_COUNT) begin
      prdata = {{(32 - CNT_W){1'b0}}, n_active};
    end else begin
      prdata = 32'h0;
    end
  end

endmodule

FILE: hdl/reed_solomon_parity_encoder.sv
// reed_solomon_parity_encoder: top level, a chain of rsp_cell stages with
// the rsp_cfg register and rebuild sequencer; uses rsp_pkg
//
//   channel  | dir | handshake          | word
//   ---------+-----+--------------------+----------------------------------
//   in       | in  | in_valid/in_ready  | in_word_t  {data_byte, last_byte}
//   out      | out | out_valid/out_ready| out_word_t {parity_byte, last_parity}
//   apb      | in  | psel/penable/...   | parity_count at byte address 0
//
// one data word per cycle while in_ready is high; each word updates every
// remainder cell in parallel; the word marked last loads the parity chain,
// which then emits n words, one per cycle while out_ready is high; a new last
// word waits until the chain is free or frees now; after reset and after each
// parity_count write the generator is rebuilt in n steps (10 after reset), one
// per cycle, with in_ready low; a stall on out never blocks non-last data words
module reed_solomon_parity_encoder import rsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic             clear;
  logic             build;
  logic [7:0]       root;
  logic [CNT_W-1:0] n_active;

  // words still waiting in the parity chain
  logic [CNT_W-1:0] pend;
  logic [CNT_W-1:0] pend_next;

  logic      in_fire;
  logic      out_fire;
  logic      load_ok;
  logic [7:0] fb;
  cell_cmd_t cmd;

  // neighbor links; one extra entry closes the open end of each chain
  logic [7:0] g_chain   [MAX_PARITY+1];
  logic [7:0] r_chain   [MAX_PARITY+1];
  logic [7:0] par_chain [MAX_PARITY+1];

  assign pready = 1'b1;

  rsp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .clear    (clear),
    .build    (build),
    .root     (root),
    .n_active (n_active)
  );

  // a last word may load when the chain is empty or its final word leaves now
  assign load_ok   = (pend == '0) || ((pend == CNT_W'(1)) && out_ready);
  assign in_ready  = ~build & (~in_word.last_byte | load_ok);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = (pend != '0);
  assign out_fire  = out_valid & out_ready;

  assign fb = in_word.data_byte ^ r_chain[0];

  always_comb begin
    cmd.clear  = clear;
    cmd.build  = build;
    cmd.encode = in_fire;
    cmd.load   = in_fire & in_word.last_byte;
    cmd.drain  = out_fire;
  end

  always_comb begin
    priority if (cmd.load) begin
      pend_next = n_active;
    end else if (out_fire) begin
      pend_next = pend - CNT_W'(1);
    end else begin
      pend_next = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // generator's implicit leading one feeds the first cell
  assign g_chain[0]            = GF_ONE;
  assign r_chain[MAX_PARITY]   = 8'h00;
  assign par_chain[MAX_PARITY] = 8'h00;

  // cells past the active count keep a zero coefficient and a zero remainder
  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
    rsp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .fb        (fb),
      .root      (root),
      .g_left    (g_chain[i]),
      .r_right   (r_chain[i+1]),
      .par_right (par_chain[i+1]),
      .g         (g_chain[i+1]),
      .r         (r_chain[i]),
      .par       (par_chain[i])
    );
  end

  assign out_word.parity_byte = par_chain[0];
  assign out_word.last_parity = (pend == CNT_W'(1));

endmodule

FILE: hdl/rsp_checker.sv
// rsp_checker: port-level assertions for reed_solomon_parity_encoder and the
// bind that attaches them; uses rsp_pkg
module rsp_checker import rsp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input in_word_t           in_word,
  input logic               out_valid,
  input logic               out_ready,
  input out_word_t          out_word,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // generator rebuild follows reset
  a_reset_build: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("input ready during rebuild after reset");

  // a parity count write starts a rebuild
  a_cfg_build: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_PARITY_COUNT) |=> !in_ready)
    else $error("input ready right after parity count write");

  // a last data word cannot enter while more than one parity word waits
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.last_parity && in_valid && in_word.last_byte |-> !in_ready)
    else $error("last data word accepted over pending parity");

  // the chain empties after its final word unless a new block loads
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_word.last_parity
      && !(in_valid && in_ready && in_word.last_byte) |=> !out_valid)
    else $error("parity words continue past final word");

endmodule

bind reed_solomon_parity_encoder rsp_checker u_rsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr)
);
